FILE: hw/rtl/hfii_pkg.sv
// Shared types, constants and the corner-term table for the Haar feature block.
// Used by hfii_ctrl, hfii_dp and the top level; depends on nothing else.
package hfii_pkg;

  localparam int IMG_WIDTH   = 256;
  localparam int IMG_HEIGHT  = 256;
  localparam int ENTRY_WIDTH = 24;
  localparam int COORD_W     = 8;
  localparam int DEPTH       = IMG_WIDTH * IMG_HEIGHT;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int OUT_W       = 25;
  // up to nine terms with weights summing to sixteen, plus sign
  localparam int ACC_W       = ENTRY_WIDTH + 6;
  localparam int OUT_MAX     = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN     = -(2 ** (OUT_W - 1));
  localparam int IDX_W       = 4;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_TYPE_A = 3'd1;
  localparam logic [2:0] OP_TYPE_B = 3'd2;
  localparam logic [2:0] OP_TYPE_C = 3'd3;
  localparam logic [2:0] OP_TYPE_D = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_ACC,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    XS_MIN,
    XS_MID,
    XS_MAX,
    XS_C1,
    XS_C2
  } xsel_t;

  typedef enum logic [1:0] {
    YS_MIN,
    YS_MID,
    YS_MAX
  } ysel_t;

  // one weighted corner read: value * (neg ? -1 : 1) * 2**shift
  typedef struct packed {
    xsel_t      xs;
    ysel_t      ys;
    logic       neg;
    logic [1:0] shift;
  } term_t;

  typedef struct packed {
    logic             capture;
    logic             clear;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       out_free;
  } status_t;

  // number of distinct corner reads per feature type
  function automatic logic [IDX_W-1:0] term_count(input logic [2:0] op);
    case (op)
      OP_TYPE_A: term_count = IDX_W'(6);
      OP_TYPE_B: term_count = IDX_W'(6);
      OP_TYPE_C: term_count = IDX_W'(8);
      OP_TYPE_D: term_count = IDX_W'(9);
      default:   term_count = '0;
    endcase
  endfunction

  function automatic term_t mk(input xsel_t xs, input ysel_t ys, input logic neg,
                               input logic [1:0] shift);
    term_t t;
    t.xs    = xs;
    t.ys    = ys;
    t.neg   = neg;
    t.shift = shift;
    return t;
  endfunction

  // box sums folded together: shared corners carry merged weights
  function automatic term_t term_lookup(input logic [2:0] op, input logic [IDX_W-1:0] idx);
    term_t t;
    t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
    case (op)
      OP_TYPE_A: begin
        case (idx)
          4'd0:    t = mk(XS_MID, YS_MAX, 1'b0, 2'd1);
          4'd1:    t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
          4'd2:    t = mk(XS_MID, YS_MIN, 1'b1, 2'd1);
          4'd3:    t = mk(XS_MIN, YS_MAX, 1'b1, 2'd0);
          4'd4:    t = mk(XS_MAX, YS_MAX, 1'b1, 2'd0);
          4'd5:    t = mk(XS_MAX, YS_MIN, 1'b0, 2'd0);
          default: t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
        endcase
      end
      OP_TYPE_B: begin
        case (idx)
          4'd0:    t = mk(XS_MAX, YS_MAX, 1'b0, 2'd0);
          4'd1:    t = mk(XS_MIN, YS_MID, 1'b0, 2'd1);
          4'd2:    t = mk(XS_MAX, YS_MID, 1'b1, 2'd1);
          4'd3:    t = mk(XS_MIN, YS_MAX, 1'b1, 2'd0);
          4'd4:    t = mk(XS_MIN, YS_MIN, 1'b1, 2'd0);
          4'd5:    t = mk(XS_MAX, YS_MIN, 1'b0, 2'd0);
          default: t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
        endcase
      end
      OP_TYPE_C: begin
        case (idx)
          4'd0:    t = mk(XS_C1,  YS_MAX, 1'b0, 2'd1);
          4'd1:    t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
          4'd2:    t = mk(XS_C1,  YS_MIN, 1'b1, 2'd1);
          4'd3:    t = mk(XS_MIN, YS_MAX, 1'b1, 2'd0);
          4'd4:    t = mk(XS_MAX, YS_MAX, 1'b0, 2'd0);
          4'd5:    t = mk(XS_C2,  YS_MIN, 1'b0, 2'd1);
          4'd6:    t = mk(XS_MAX, YS_MIN, 1'b1, 2'd0);
          4'd7:    t = mk(XS_C2,  YS_MAX, 1'b1, 2'd1);
          default: t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
        endcase
      end
      OP_TYPE_D: begin
        case (idx)
          4'd0:    t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
          4'd1:    t = mk(XS_MID, YS_MIN, 1'b1, 2'd1);
          4'd2:    t = mk(XS_MAX, YS_MIN, 1'b0, 2'd0);
          4'd3:    t = mk(XS_MIN, YS_MID, 1'b1, 2'd1);
          4'd4:    t = mk(XS_MID, YS_MID, 1'b0, 2'd2);
          4'd5:    t = mk(XS_MAX, YS_MID, 1'b1, 2'd1);
          4'd6:    t = mk(XS_MIN, YS_MAX, 1'b0, 2'd0);
          4'd7:    t = mk(XS_MID, YS_MAX, 1'b1, 2'd1);
          4'd8:    t = mk(XS_MAX, YS_MAX, 1'b0, 2'd0);
          default: t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
        endcase
      end
      default: t = mk(XS_MIN, YS_MIN, 1'b0, 2'd0);
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/haar_feature_from_integral_image.sv
// Haar-like feature evaluator over an integral image of 256 x 256 entries held in a
// single-port memory. Op 0 writes one entry and is done in the accept cycle, so a new
// beat is taken on the next cycle. A feature beat first forms the midpoints, then issues
// one corner read per cycle (6 for types a and b, 8 for c, 9 for d) on the memory
// port, folds in the last read, hands the result to the output register once that
// register is free and goes back to idle; ops 5 to 7 read nothing and go straight to
// the hand-off. No new beat is taken until idle is reached. The memory needs no
// clearing; entries must be written before they are read, and the block itself does
// not enforce this.
// Depends on hfii_pkg, hfii_ctrl and hfii_dp.
module haar_feature_from_integral_image (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // op[2:0], x_min[10:3], y_min[18:11], x_max[26:19], y_max[34:27],
  // entry_value[58:35], zero[63:59]
  input  logic [hfii_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // feature_value[24:0] (two's complement), zero[31:25]
  output logic [hfii_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import hfii_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic signed [OUT_W-1:0] feature_value;

  hfii_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tdata[2:0]),
    .status    (status),
    .cmd       (cmd)
  );

  hfii_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_op             (in_tdata[2:0]),
    .in_x_min          (in_tdata[10:3]),
    .in_y_min          (in_tdata[18:11]),
    .in_x_max          (in_tdata[26:19]),
    .in_y_max          (in_tdata[34:27]),
    .in_entry_value    (in_tdata[58:35]),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_feature_value (feature_value)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, feature_value};

endmodule

FILE: hw/rtl/hfii_ctrl.sv
// Sequencer for the Haar feature block: accepts beats and steps through corner reads.
// Depends on hfii_pkg; drives hfii_dp through cmd_t and watches status_t.
module hfii_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_op,
  input  hfii_pkg::status_t status,
  output hfii_pkg::cmd_t    cmd
);
  import hfii_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] nterms;
  logic             in_accept;

  assign nterms    = term_count(status.op);
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd.capture = 1'b0;
    cmd.clear   = 1'b0;
    cmd.issue   = 1'b0;
    cmd.idx     = idx_r;
    cmd.finish  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_accept;
        // loads are written at the accept edge and need no further work
        if (in_accept && in_op != OP_LOAD) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.clear = 1'b1;
        idx_nxt   = '0;
        state_nxt = (nterms == '0) ? ST_FINISH : ST_READ;
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        if (idx_r == nterms - IDX_W'(1)) begin
          state_nxt = ST_ACC;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_ACC: begin
        // last read data folds into the sum here
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_feature_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op != OP_LOAD) |=> state_r == ST_PREP)
    else $error("feature beat did not start a computation");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (cmd.idx < nterms))
    else $error("corner read issued beyond term count");

  a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && status.out_free) |=> state_r == ST_IDLE)
    else $error("result hand-off did not return to idle");

endmodule

FILE: hw/rtl/hfii_dp.sv
// Datapath: integral image memory, midpoint unit, weighted accumulator, output register.
// Depends on hfii_pkg; controlled by hfii_ctrl through cmd_t.
module hfii_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hfii_pkg::cmd_t                   cmd,
  output hfii_pkg::status_t                status,
  input  logic [2:0]                       in_op,
  input  logic [hfii_pkg::COORD_W-1:0]     in_x_min,
  input  logic [hfii_pkg::COORD_W-1:0]     in_y_min,
  input  logic [hfii_pkg::COORD_W-1:0]     in_x_max,
  input  logic [hfii_pkg::COORD_W-1:0]     in_y_max,
  input  logic [hfii_pkg::ENTRY_WIDTH-1:0] in_entry_value,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic signed [hfii_pkg::OUT_W-1:0] out_feature_value
);
  import hfii_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

  // truncating divide by 3 via reciprocal 171/512, exact below 512
  function automatic logic [COORD_W-1:0] div3(input logic [COORD_W:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd171;
    return p[16:9];
  endfunction

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];

  logic [2:0]             op_r;
  logic [COORD_W-1:0]     xa_r, ya_r, xb_r, yb_r;
  logic [COORD_W-1:0]     mx_r, my_r, c1_r, c2_r;
  logic [COORD_W:0]       sum_x, sum_y, c1_sum, c2_sum;
  term_t                  term;
  term_t                  coef_r;
  logic [COORD_W-1:0]     rx, ry;
  logic                   rd_ok;
  logic                   rd_ok_r;
  logic [ENTRY_WIDTH-1:0] rd_data_r;
  logic                   valid_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] term_val;
  logic                   out_valid_r;
  logic signed [OUT_W-1:0] out_data_r;
  logic signed [OUT_W-1:0] sat_val;
  logic                   wr_ok;

  assign sum_x  = {1'b0, xa_r} + {1'b0, xb_r};
  assign sum_y  = {1'b0, ya_r} + {1'b0, yb_r};
  assign c1_sum = {1'b0, div3({xa_r, 1'b0})} + {1'b0, div3({1'b0, xb_r})};
  assign c2_sum = {1'b0, div3({1'b0, xa_r})} + {1'b0, div3({xb_r, 1'b0})};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      xa_r <= in_x_min;
      ya_r <= in_y_min;
      xb_r <= in_x_max;
      yb_r <= in_y_max;
    end
    if (cmd.clear) begin
      mx_r <= sum_x[COORD_W:1];
      my_r <= sum_y[COORD_W:1];
      c1_r <= c1_sum[COORD_W-1:0];
      c2_r <= c2_sum[COORD_W-1:0];
    end
  end

  assign term = term_lookup(op_r, cmd.idx);

  always_comb begin
    case (term.xs)
      XS_MIN:  rx = xa_r;
      XS_MID:  rx = mx_r;
      XS_MAX:  rx = xb_r;
      XS_C1:   rx = c1_r;
      XS_C2:   rx = c2_r;
      default: rx = xa_r;
    endcase
    case (term.ys)
      YS_MIN:  ry = ya_r;
      YS_MID:  ry = my_r;
      YS_MAX:  ry = yb_r;
      default: ry = ya_r;
    endcase
  end

  assign rd_ok = (int'(rx) < IMG_WIDTH) && (int'(ry) < IMG_HEIGHT);
  assign wr_ok = (int'(in_x_min) < IMG_WIDTH) && (int'(in_y_min) < IMG_HEIGHT);

  // column-major layout: address = x * height + y
  always_ff @(posedge clk) begin
    if (cmd.capture && in_op == OP_LOAD && wr_ok) begin
      mem[ADDR_W'(int'(in_x_min) * IMG_HEIGHT + int'(in_y_min))] <= in_entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[ADDR_W'(int'(rx) * IMG_HEIGHT + int'(ry))];
      rd_ok_r   <= rd_ok;
      coef_r    <= term;
    end
  end

  always_comb begin
    term_val = rd_ok_r ? $signed({{(ACC_W - ENTRY_WIDTH){1'b0}}, rd_data_r}) : '0;
    term_val = term_val <<< coef_r.shift;
    if (coef_r.neg) begin
      term_val = -term_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc_r <= '0;
    end else if (valid_r) begin
      acc_r <= acc_r + term_val;
    end
  end

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat_val = OUT_W'(SAT_HI);
    end else if (acc_r < SAT_LO) begin
      sat_val = OUT_W'(SAT_LO);
    end else begin
      sat_val = acc_r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= sat_val;
    end
  end

  assign status.op       = op_r;
  assign status.out_free = !out_valid_r || out_tready;

  assign out_tvalid        = out_valid_r;
  assign out_feature_value = out_data_r;

endmodule
